// File: hw/rtl/baro_pressure_compensation_assert.svh
// assertion macros for the barometric pressure compensation block
// used by the port checker; needs clk_i and rst_ni in the including scope
`ifndef BARO_PRESSURE_COMPENSATION_ASSERT_SVH
`define BARO_PRESSURE_COMPENSATION_ASSERT_SVH

// checked only outside reset
`define BPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define BPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: hw/rtl/bpc_pkg.sv
// shared constants, register codes and inter-module types of the
// barometric pressure compensation block; no dependencies
package bpc_pkg;

  localparam int NumRegs   = 6;
  localparam int CalibW    = 16;
  localparam int RawW      = 24;
  localparam int TempW     = 20;
  localparam int PresW     = 32;
  localparam int ApbDataW  = 32;
  localparam int PaddrW    = $clog2(4 * NumRegs);
  localparam int RegIdxW   = PaddrW - 2;

  // datapath widths
  localparam int DtW       = RawW + 1;          // raw temperature minus reference
  localparam int MulW      = DtW + CalibW + 1;  // dt times a calibration word
  localparam int DtSqW     = 2 * DtW;           // dt squared
  localparam int SqW       = 2 * TempW;         // temperature deviation squared
  localparam int OffW      = 44;                // offset and sensitivity
  localparam int SensLoW   = 22;                // low slice for the split multiply
  localparam int SensHiW   = OffW - SensLoW;
  localparam int PlW       = RawW + SensLoW;
  localparam int PhW       = RawW + 1 + SensHiW;
  localparam int ProdW     = PhW + SensLoW;
  localparam int QW        = ProdW - 21;
  localparam int PW        = QW - 15;
  localparam int NumStages = 9;

  localparam int TempRef   = 2000;
  localparam int TempLow   = -1500;

  typedef enum logic [RegIdxW-1:0] {
    RegSens     = 3'd0,
    RegOffset   = 3'd1,
    RegTcs      = 3'd2,
    RegTco      = 3'd3,
    RegTref     = 3'd4,
    RegTempSens = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [CalibW-1:0] c1;
    logic [CalibW-1:0] c2;
    logic [CalibW-1:0] c3;
    logic [CalibW-1:0] c4;
    logic [CalibW-1:0] c5;
    logic [CalibW-1:0] c6;
  } cfg_t;

  typedef struct packed {
    logic        [RawW-1:0]  d1;
    logic signed [TempW-1:0] temp;
    logic signed [OffW-1:0]  off;
    logic signed [OffW-1:0]  sens;
  } comp_t;

  typedef struct packed {
    logic [NumStages-1:0] load;
  } pipe_ctrl_t;

endpackage

// File: hw/rtl/bpc_if.sv
// valid/ready channels of the barometric pressure compensation block
// depends on bpc_pkg for the field widths
interface bpc_in_if;
  logic                      valid;
  logic                      ready;
  logic [bpc_pkg::RawW-1:0]  raw_pressure;
  logic [bpc_pkg::RawW-1:0]  raw_temperature;

  modport source (output valid, output raw_pressure, output raw_temperature, input ready);
  modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

interface bpc_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [bpc_pkg::TempW-1:0] temperature_centi;
  logic signed [bpc_pkg::PresW-1:0] pressure_centi_mbar;
  logic                             pressure_clipped;

  modport source (output valid, output temperature_centi, output pressure_centi_mbar,
                  output pressure_clipped, input ready);
  modport sink   (input valid, input temperature_centi, input pressure_centi_mbar,
                  input pressure_clipped, output ready);
endinterface

// File: hw/rtl/bpc_cfg_regs.sv
// apb calibration register file, six 16-bit words
// depends on bpc_pkg
module bpc_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bpc_pkg::PaddrW-1:0]    paddr,
  input  logic [bpc_pkg::ApbDataW-1:0]  pwdata,
  output logic [bpc_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready,
  output bpc_pkg::cfg_t                 cfg_o
);

  bpc_pkg::cfg_t     cfg_q, cfg_d;
  bpc_pkg::reg_idx_e idx;
  logic              wr_en;

  assign idx    = bpc_pkg::reg_idx_e'(paddr[bpc_pkg::PaddrW-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        bpc_pkg::RegSens:     cfg_d.c1 = pwdata[bpc_pkg::CalibW-1:0];
        bpc_pkg::RegOffset:   cfg_d.c2 = pwdata[bpc_pkg::CalibW-1:0];
        bpc_pkg::RegTcs:      cfg_d.c3 = pwdata[bpc_pkg::CalibW-1:0];
        bpc_pkg::RegTco:      cfg_d.c4 = pwdata[bpc_pkg::CalibW-1:0];
        bpc_pkg::RegTref:     cfg_d.c5 = pwdata[bpc_pkg::CalibW-1:0];
        bpc_pkg::RegTempSens: cfg_d.c6 = pwdata[bpc_pkg::CalibW-1:0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      bpc_pkg::RegSens:     prdata = bpc_pkg::ApbDataW'(cfg_q.c1);
      bpc_pkg::RegOffset:   prdata = bpc_pkg::ApbDataW'(cfg_q.c2);
      bpc_pkg::RegTcs:      prdata = bpc_pkg::ApbDataW'(cfg_q.c3);
      bpc_pkg::RegTco:      prdata = bpc_pkg::ApbDataW'(cfg_q.c4);
      bpc_pkg::RegTref:     prdata = bpc_pkg::ApbDataW'(cfg_q.c5);
      bpc_pkg::RegTempSens: prdata = bpc_pkg::ApbDataW'(cfg_q.c6);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// File: hw/rtl/bpc_pipe_ctrl.sv
// valid bits and per-stage load enables of the compensation pipeline
// depends on bpc_pkg
module bpc_pipe_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                out_ready_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  output bpc_pkg::pipe_ctrl_t ctrl_o
);

  localparam int N = bpc_pkg::NumStages;

  logic [N-1:0] valid_q, valid_d;
  logic [N-1:0] load;

  // a stage takes new data when it is empty or its content moves on
  always_comb begin
    load[N-1] = !valid_q[N-1] || out_ready_i;
    for (int k = N - 2; k >= 0; k--) begin
      load[k] = !valid_q[k] || load[k+1];
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (load[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k < N; k++) begin
      if (load[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign ctrl_o.load = load;
  assign in_ready_o  = load[0];
  assign out_valid_o = valid_q[N-1];

endmodule

// File: hw/rtl/bpc_comp.sv
// stages one to six: temperature, first and second order offset and sensitivity
// depends on bpc_pkg
module bpc_comp (
  input  logic                     clk_i,
  input  logic [5:0]               load_i,
  input  logic [bpc_pkg::RawW-1:0] raw_pressure_i,
  input  logic [bpc_pkg::RawW-1:0] raw_temperature_i,
  input  bpc_pkg::cfg_t            cfg_i,
  output bpc_pkg::comp_t           comp_o
);

  localparam int RawW  = bpc_pkg::RawW;
  localparam int TempW = bpc_pkg::TempW;
  localparam int DtW   = bpc_pkg::DtW;
  localparam int MulW  = bpc_pkg::MulW;
  localparam int DtSqW = bpc_pkg::DtSqW;
  localparam int SqW   = bpc_pkg::SqW;
  localparam int OffW  = bpc_pkg::OffW;
  localparam int CalibW = bpc_pkg::CalibW;

  localparam logic signed [TempW-1:0] TempRefC = TempW'(bpc_pkg::TempRef);
  localparam logic signed [TempW-1:0] TempLowC = TempW'(bpc_pkg::TempLow);

  // stage 1
  logic        [RawW-1:0]  d1_s1_q;
  logic signed [DtW-1:0]   dt_q, dt_d;
  // stage 2
  logic        [RawW-1:0]  d1_s2_q;
  logic signed [MulW-1:0]  mt_q, mo_q, ms_q;
  logic signed [DtSqW-1:0] dtsq_q;
  // stage 3
  logic        [RawW-1:0]  d1_s3_q;
  logic signed [TempW-1:0] temp1_s3_q, temp1_d, t2_s3_q, t2_d;
  logic signed [OffW-1:0]  off1_s3_q, off1_d, sens1_s3_q, sens1_d;
  // stage 4
  logic        [RawW-1:0]  d1_s4_q;
  logic signed [TempW-1:0] temp1_s4_q, t2_s4_q, dev_w, ext_w;
  logic signed [OffW-1:0]  off1_s4_q, sens1_s4_q;
  logic signed [SqW-1:0]   sq_q, sq2_q;
  logic                    cold_q, very_cold_q;
  // stage 5
  logic        [RawW-1:0]  d1_s5_q;
  logic signed [TempW-1:0] temp_s5_q, temp_d;
  logic signed [OffW-1:0]  off1_s5_q, sens1_s5_q, off2_q, off2_d, sens2_q, sens2_d;
  logic signed [OffW-1:0]  sq5_w, sq2_w, sq2x7_w, sq2x11_w;
  // stage 6
  bpc_pkg::comp_t          comp_q, comp_d;

  assign dt_d = $signed({1'b0, raw_temperature_i}) - $signed({1'b0, cfg_i.c5, 8'h00});

  always_ff @(posedge clk_i) begin
    if (load_i[0]) begin
      d1_s1_q <= raw_pressure_i;
      dt_q    <= dt_d;
    end
  end

  // four multipliers in parallel
  always_ff @(posedge clk_i) begin
    if (load_i[1]) begin
      d1_s2_q <= d1_s1_q;
      mt_q    <= dt_q * $signed({1'b0, cfg_i.c6});
      mo_q    <= dt_q * $signed({1'b0, cfg_i.c4});
      ms_q    <= dt_q * $signed({1'b0, cfg_i.c3});
      dtsq_q  <= dt_q * dt_q;
    end
  end

  assign temp1_d = TempRefC + TempW'(mt_q >>> 23);
  assign t2_d    = TempW'(dtsq_q >>> 31);
  assign off1_d  = $signed({(OffW-CalibW-16)'(0), cfg_i.c2, 16'h0000}) + OffW'(mo_q >>> 7);
  assign sens1_d = $signed({(OffW-CalibW-15)'(0), cfg_i.c1, 15'h0000}) + OffW'(ms_q >>> 8);

  always_ff @(posedge clk_i) begin
    if (load_i[2]) begin
      d1_s3_q    <= d1_s2_q;
      temp1_s3_q <= temp1_d;
      t2_s3_q    <= t2_d;
      off1_s3_q  <= off1_d;
      sens1_s3_q <= sens1_d;
    end
  end

  // squares of the deviation from 20 degC and from -15 degC
  assign dev_w = temp1_s3_q - TempRefC;
  assign ext_w = temp1_s3_q - TempLowC;

  always_ff @(posedge clk_i) begin
    if (load_i[3]) begin
      d1_s4_q     <= d1_s3_q;
      temp1_s4_q  <= temp1_s3_q;
      t2_s4_q     <= t2_s3_q;
      off1_s4_q   <= off1_s3_q;
      sens1_s4_q  <= sens1_s3_q;
      sq_q        <= dev_w * dev_w;
      sq2_q       <= ext_w * ext_w;
      cold_q      <= temp1_s3_q < TempRefC;
      very_cold_q <= temp1_s3_q < TempLowC;
    end
  end

  // constant factors as shift-add
  assign sq5_w    = (OffW'(sq_q) <<< 2) + OffW'(sq_q);
  assign sq2_w    = OffW'(sq2_q);
  assign sq2x7_w  = (sq2_w <<< 3) - sq2_w;
  assign sq2x11_w = (sq2_w <<< 3) + (sq2_w <<< 1) + sq2_w;

  always_comb begin
    off2_d  = '0;
    sens2_d = '0;
    temp_d  = temp1_s4_q;
    if (cold_q) begin
      off2_d  = sq5_w >>> 1;
      sens2_d = sq5_w >>> 2;
      temp_d  = temp1_s4_q - t2_s4_q;
      if (very_cold_q) begin
        off2_d  = (sq5_w >>> 1) + sq2x7_w;
        sens2_d = (sq5_w >>> 2) + (sq2x11_w >>> 1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i[4]) begin
      d1_s5_q    <= d1_s4_q;
      temp_s5_q  <= temp_d;
      off1_s5_q  <= off1_s4_q;
      sens1_s5_q <= sens1_s4_q;
      off2_q     <= off2_d;
      sens2_q    <= sens2_d;
    end
  end

  always_comb begin
    comp_d.d1   = d1_s5_q;
    comp_d.temp = temp_s5_q;
    comp_d.off  = off1_s5_q - off2_q;
    comp_d.sens = sens1_s5_q - sens2_q;
  end

  always_ff @(posedge clk_i) begin
    if (load_i[5]) begin
      comp_q <= comp_d;
    end
  end

  assign comp_o = comp_q;

endmodule

// File: hw/rtl/bpc_pressure.sv
// stages seven to nine: split raw pressure times sensitivity, offset, saturation
// depends on bpc_pkg
module bpc_pressure (
  input  logic                             clk_i,
  input  logic [2:0]                       load_i,
  input  bpc_pkg::comp_t                   comp_i,
  output logic signed [bpc_pkg::TempW-1:0] temperature_o,
  output logic signed [bpc_pkg::PresW-1:0] pressure_o,
  output logic                             clipped_o
);

  localparam int TempW   = bpc_pkg::TempW;
  localparam int PresW   = bpc_pkg::PresW;
  localparam int OffW    = bpc_pkg::OffW;
  localparam int SensLoW = bpc_pkg::SensLoW;
  localparam int PlW     = bpc_pkg::PlW;
  localparam int PhW     = bpc_pkg::PhW;
  localparam int ProdW   = bpc_pkg::ProdW;
  localparam int QW      = bpc_pkg::QW;
  localparam int PW      = bpc_pkg::PW;

  localparam logic signed [PresW-1:0] PresMax = {1'b0, {(PresW-1){1'b1}}};
  localparam logic signed [PresW-1:0] PresMin = {1'b1, {(PresW-1){1'b0}}};

  logic        [PlW-1:0]   pl_q;
  logic signed [PhW-1:0]   ph_q;
  logic signed [TempW-1:0] temp_s7_q, temp_s8_q, temp_q;
  logic signed [OffW-1:0]  off_s7_q, off_s8_q;
  logic signed [ProdW-1:0] prod_q, prod_d;
  logic signed [QW-1:0]    q_w;
  logic signed [PW-1:0]    p_w;
  logic signed [PresW-1:0] pres_q, pres_d;
  logic                    clip_q, clip_d;

  // low slice unsigned, high slice signed
  always_ff @(posedge clk_i) begin
    if (load_i[0]) begin
      pl_q      <= comp_i.d1 * comp_i.sens[SensLoW-1:0];
      ph_q      <= $signed({1'b0, comp_i.d1}) * $signed(comp_i.sens[OffW-1:SensLoW]);
      temp_s7_q <= comp_i.temp;
      off_s7_q  <= comp_i.off;
    end
  end

  assign prod_d = $signed({ph_q, {SensLoW{1'b0}}}) + $signed({{(ProdW-PlW){1'b0}}, pl_q});

  always_ff @(posedge clk_i) begin
    if (load_i[1]) begin
      prod_q    <= prod_d;
      temp_s8_q <= temp_s7_q;
      off_s8_q  <= off_s7_q;
    end
  end

  assign q_w = QW'(prod_q >>> 21) - QW'(off_s8_q);
  assign p_w = q_w[QW-1:15];

  always_comb begin
    clip_d = p_w[PW-1] != p_w[PresW-1];
    pres_d = p_w[PresW-1:0];
    if (clip_d) begin
      pres_d = p_w[PW-1] ? PresMin : PresMax;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i[2]) begin
      pres_q <= pres_d;
      clip_q <= clip_d;
      temp_q <= temp_s8_q;
    end
  end

  assign temperature_o = temp_q;
  assign pressure_o    = pres_q;
  assign clipped_o     = clip_q;

endmodule

// File: hw/rtl/baro_pressure_compensation.sv
// top level of the barometric pressure compensation block
// depends on bpc_pkg, bpc_if, bpc_cfg_regs, bpc_pipe_ctrl, bpc_comp, bpc_pressure
//
// usage:
// - meas_i carries one raw pressure and one raw temperature conversion per transfer
// - result_o carries temperature in 0.01 degC, pressure in 0.01 mbar and a flag
//   that marks a saturated pressure; exactly one result transfer per input transfer
// - the user writes the six calibration words over the apb port at byte address
//   4*i only while the block is idle, which the block itself does not enforce;
//   pready is always high and reads return the word
// - result valid rises once the input has passed all nine pipeline stages; a new
//   item can be taken every cycle while result_o does not stall
// - every stage has its own valid bit; a stage loads when it is empty or its
//   content moves on, so bubbles close up while the sink stalls
// - when result_o stalls the last stage holds its value and stages behind it
//   fill up; meas_i.ready drops only once all nine stages hold items
// - reset clears the valid bits and the calibration words to zero; nothing
//   else needs clearing
module baro_pressure_compensation (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  bpc_in_if.sink                       meas_i,
  bpc_out_if.source                    result_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bpc_pkg::PaddrW-1:0]   paddr,
  input  logic [bpc_pkg::ApbDataW-1:0] pwdata,
  output logic [bpc_pkg::ApbDataW-1:0] prdata,
  output logic                         pready
);

  bpc_pkg::cfg_t       cfg;
  bpc_pkg::pipe_ctrl_t ctrl;
  bpc_pkg::comp_t      comp;

  // calibration words
  bpc_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // valid bits and stage enables
  bpc_pipe_ctrl u_pipe_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (meas_i.valid),
    .out_ready_i (result_o.ready),
    .in_ready_o  (meas_i.ready),
    .out_valid_o (result_o.valid),
    .ctrl_o      (ctrl)
  );

  // stages 1..6: temperature and compensated offset/sensitivity
  bpc_comp u_comp (
    .clk_i             (clk_i),
    .load_i            (ctrl.load[5:0]),
    .raw_pressure_i    (meas_i.raw_pressure),
    .raw_temperature_i (meas_i.raw_temperature),
    .cfg_i             (cfg),
    .comp_o            (comp)
  );

  // stages 7..9: pressure, last stage is the output register
  bpc_pressure u_pressure (
    .clk_i         (clk_i),
    .load_i        (ctrl.load[8:6]),
    .comp_i        (comp),
    .temperature_o (result_o.temperature_centi),
    .pressure_o    (result_o.pressure_centi_mbar),
    .clipped_o     (result_o.pressure_clipped)
  );

endmodule

// File: hw/rtl/bpc_checker.sv
// port checker for the barometric pressure compensation block, bound to the top
// depends on bpc_pkg and baro_pressure_compensation_assert.svh
`include "baro_pressure_compensation_assert.svh"

module bpc_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_ready_i,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  logic signed [bpc_pkg::TempW-1:0] temperature_i,
  input  logic signed [bpc_pkg::PresW-1:0] pressure_i,
  input  logic                             clipped_i
);

  localparam logic signed [bpc_pkg::PresW-1:0] PresMax = {1'b0, {(bpc_pkg::PresW-1){1'b1}}};
  localparam logic signed [bpc_pkg::PresW-1:0] PresMin = {1'b1, {(bpc_pkg::PresW-1){1'b0}}};

  logic [bpc_pkg::TempW+bpc_pkg::PresW:0] result_w;
  logic                                   stall_w;
  logic                                   at_limit_w;

  assign result_w   = {temperature_i, pressure_i, clipped_i};
  assign stall_w    = out_valid_i && !out_ready_i;
  assign at_limit_w = (pressure_i == PresMax) || (pressure_i == PresMin);

  `BPC_ASSERT_ALWAYS(a_no_result_in_reset, !rst_ni |-> !out_valid_i, "result valid in reset")
  `BPC_ASSERT(a_result_held, stall_w |=> out_valid_i && $stable(result_w), "result not held")
  `BPC_ASSERT(a_clip_value, out_valid_i && clipped_i |-> at_limit_w, "clip flag without limit")
  `BPC_ASSERT(a_ready_follows_sink, out_ready_i |-> in_ready_i, "input stalled, sink ready")

endmodule

bind baro_pressure_compensation bpc_checker u_bpc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (meas_i.ready),
  .out_valid_i   (result_o.valid),
  .out_ready_i   (result_o.ready),
  .temperature_i (result_o.temperature_centi),
  .pressure_i    (result_o.pressure_centi_mbar),
  .clipped_i     (result_o.pressure_clipped)
);
